// ===== design/lfpd_pkg.sv =====
`default_nettype none

package lfpd_pkg;

    localparam int SMP_W  = 10;
    localparam int POS_W  = 12;
    localparam int SPD_W  = 8;
    localparam int ERR_W  = 13;
    localparam int ALU_W  = 22;
    localparam int CNT_W  = 4;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Last step indexes of the shared-adder loops
    localparam logic [CNT_W-1:0] DIV_LAST = 4'd11;
    localparam logic [CNT_W-1:0] MUL_LAST = 4'd9;

    localparam logic [POS_W-1:0] POS_CENTRE = 12'd2000;
    localparam logic [POS_W-1:0] POS_RIGHT  = 12'd4000;

    // Register indexes
    localparam logic [2:0] REG_NOISE = 3'd0;
    localparam logic [2:0] REG_LINE  = 3'd1;
    localparam logic [2:0] REG_PGAIN = 3'd2;
    localparam logic [2:0] REG_DGAIN = 3'd3;
    localparam logic [2:0] REG_BASE  = 3'd4;
    localparam logic [2:0] REG_MAX   = 3'd5;

    // Register reset values
    localparam logic [SMP_W-1:0] RST_NOISE = 10'd50;
    localparam logic [SMP_W-1:0] RST_LINE  = 10'd200;
    localparam logic [SMP_W-1:0] RST_PGAIN = 10'd64;
    localparam logic [SMP_W-1:0] RST_DGAIN = 10'd256;
    localparam logic [SPD_W-1:0] RST_BASE  = 8'd125;
    localparam logic [SPD_W-1:0] RST_MAX   = 8'd125;

    typedef struct packed {
        logic [SMP_W-1:0] sample_left_mid;
        logic [SMP_W-1:0] sample_centre;
        logic [SMP_W-1:0] sample_right_mid;
    } t_in;

    typedef struct packed {
        logic             track_found;
        logic [POS_W-1:0] line_position;
        logic [SPD_W-1:0] left_speed;
        logic [SPD_W-1:0] right_speed;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_ERR,
        ST_MULP,
        ST_MULD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic idle;
        logic prep;
        logic div;
        logic err;
        logic mulp;
        logic muld;
        logic done;
        logic last;
    } t_ctrl;

endpackage

`default_nettype wire

// ===== design/line_follow_pd_steering_core.sv =====
`default_nettype none
// Flow: with the line seen and a sample above noise, a 12-step divide and two 10-step
//   multiplies on the shared adder; otherwise only the multiplies; none when the track is lost.
// One item at a time: a new item is taken only while the sequencer is idle.
// The output register frees the input side while a result waits to be taken.
// Reset (synchronous, active low) restores register defaults and clears position/error history.

module line_follow_pd_steering_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input item channel
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire lfpd_pkg::t_in                  i_data,
    // result channel
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output lfpd_pkg::t_out                      o_data,
    // register port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lfpd_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [lfpd_pkg::DATA_W-1:0]    pwdata,
    output logic      [lfpd_pkg::DATA_W-1:0]    prdata,
    output logic                                pready
);

    // Clamp a signed speed into 0..max
    function automatic logic [lfpd_pkg::SPD_W-1:0] clamp_speed(
        input logic signed [16:0]             v,
        input logic [lfpd_pkg::SPD_W-1:0]     mx
    );
        logic [lfpd_pkg::SPD_W-1:0] res;
        if (v[16])                        res = '0;
        else if (v > $signed({9'b0, mx})) res = mx;
        else                              res = v[lfpd_pkg::SPD_W-1:0];
        return res;
    endfunction

    // ---------------------------------------------------------------- registers
    logic [lfpd_pkg::SMP_W-1:0] r_noise, r_line, r_pgain, r_dgain;
    logic [lfpd_pkg::SPD_W-1:0] r_base, r_max;
    logic                       w_wr;
    logic [2:0]                 w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        case (w_idx)
            lfpd_pkg::REG_NOISE: prdata = {22'b0, r_noise};
            lfpd_pkg::REG_LINE:  prdata = {22'b0, r_line};
            lfpd_pkg::REG_PGAIN: prdata = {22'b0, r_pgain};
            lfpd_pkg::REG_DGAIN: prdata = {22'b0, r_dgain};
            lfpd_pkg::REG_BASE:  prdata = {24'b0, r_base};
            lfpd_pkg::REG_MAX:   prdata = {24'b0, r_max};
            default:             prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- sequencer
    lfpd_pkg::t_ctrl w_ctrl;
    logic            w_acc;
    logic            w_out_free;
    logic            w_lost;
    logic            w_div;
    logic            r_ovalid;

    assign o_ready    = w_ctrl.idle;
    assign w_acc      = i_valid && o_ready;
    assign w_out_free = !r_ovalid || i_ready;

    lfpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_valid),
        .i_lost     (w_lost),
        .i_div      (w_div),
        .i_out_free (w_out_free),
        .o_ctrl     (w_ctrl)
    );

    // ---------------------------------------------------------------- datapath regs
    lfpd_pkg::t_in               r_smp;
    logic [lfpd_pkg::POS_W-1:0]  r_pos;
    logic [lfpd_pkg::POS_W-1:0]  r_sum;
    logic [lfpd_pkg::POS_W-1:0]  r_rem;
    logic [lfpd_pkg::POS_W-1:0]  r_dvd;
    logic                        r_lost;
    logic                        r_divused;
    logic [lfpd_pkg::ALU_W-1:0]  r_acc;
    logic [lfpd_pkg::ALU_W-1:0]  r_mcand;
    logic [lfpd_pkg::SMP_W-1:0]  r_mplier;
    logic                        r_esign;
    logic                        r_dsign;
    logic [lfpd_pkg::POS_W-1:0]  r_dmag;
    logic [13:0]                 r_pmag;
    lfpd_pkg::t_out              r_out;
    // history, cleared by reset
    logic [lfpd_pkg::POS_W-1:0]  r_lastpos;
    logic signed [lfpd_pkg::ERR_W-1:0] r_lasterr;

    // ---------------------------------------------------------------- sample filter
    // Keep only samples above the noise floor; weighted sum is 1000*(m0 + 2*m1 + 3*m2).
    logic [lfpd_pkg::SMP_W-1:0] w_m0, w_m1, w_m2;
    logic                       w_on_line;
    logic [lfpd_pkg::POS_W-1:0] w_sum;
    logic [12:0]                w_tsum;
    logic [22:0]                w_wsum;
    logic [lfpd_pkg::POS_W-1:0] w_alt_pos;

    assign w_m0 = (r_smp.sample_left_mid  > r_noise) ? r_smp.sample_left_mid  : '0;
    assign w_m1 = (r_smp.sample_centre    > r_noise) ? r_smp.sample_centre    : '0;
    assign w_m2 = (r_smp.sample_right_mid > r_noise) ? r_smp.sample_right_mid : '0;

    assign w_on_line = (r_smp.sample_left_mid > r_line) || (r_smp.sample_centre > r_line) ||
                       (r_smp.sample_right_mid > r_line);

    assign w_sum  = {2'b0, w_m0} + {2'b0, w_m1} + {2'b0, w_m2};
    assign w_tsum = {3'b0, w_m0} + {2'b0, w_m1, 1'b0} + ({3'b0, w_m2} + {2'b0, w_m2, 1'b0});
    // times 1000 = 1024 - 16 - 8
    assign w_wsum = {w_tsum, 10'b0} - {6'b0, w_tsum, 4'b0} - {7'b0, w_tsum, 3'b0};

    assign w_lost = !w_on_line && (w_sum == '0);
    assign w_div  = w_on_line && (w_sum != '0);

    // Line seen without signal: hold last position. Line not seen: pick the edge
    // on the side of centre where the line was last.
    assign w_alt_pos = w_on_line ? r_lastpos
                                 : ((r_lastpos < lfpd_pkg::POS_CENTRE) ? '0 : lfpd_pkg::POS_RIGHT);

    // ---------------------------------------------------------------- shared adder
    logic [lfpd_pkg::ALU_W-1:0] w_alu_a, w_alu_b, w_alu_res;
    logic                       w_alu_sub, w_alu_carry;

    // Divide step: trial-subtract the divisor from the shifted remainder.
    // Multiply step: add the shifted multiplicand when the multiplier bit is set.
    always_comb begin
        if (w_ctrl.div) begin
            w_alu_a   = {9'b0, r_rem, r_dvd[lfpd_pkg::POS_W-1]};
            w_alu_b   = {10'b0, r_sum};
            w_alu_sub = 1'b1;
        end else begin
            w_alu_a   = r_acc;
            w_alu_b   = r_mplier[0] ? r_mcand : '0;
            w_alu_sub = 1'b0;
        end
    end

    lfpd_alu u_alu (
        .i_a     (w_alu_a),
        .i_b     (w_alu_b),
        .i_sub   (w_alu_sub),
        .o_res   (w_alu_res),
        .o_carry (w_alu_carry)
    );

    // ---------------------------------------------------------------- error terms
    logic signed [lfpd_pkg::ERR_W-1:0] w_err, w_eneg;
    logic signed [13:0]                w_derr, w_dneg;
    logic [lfpd_pkg::POS_W-1:0]        w_emag, w_dmag;

    assign w_err  = $signed({1'b0, r_pos}) - $signed({1'b0, lfpd_pkg::POS_CENTRE});
    assign w_derr = $signed({w_err[12], w_err}) - $signed({r_lasterr[12], r_lasterr});
    assign w_eneg = -w_err;
    assign w_dneg = -w_derr;
    assign w_emag = w_err[12]  ? w_eneg[11:0] : w_err[11:0];
    assign w_dmag = w_derr[13] ? w_dneg[11:0] : w_derr[11:0];

    // ---------------------------------------------------------------- PD combine
    // Products are magnitudes; dropping 8 bits then restoring the sign truncates toward zero.
    logic signed [15:0] w_pterm, w_dterm, w_diff;
    logic signed [16:0] w_left, w_right;

    assign w_pterm = r_esign ? -$signed({2'b0, r_pmag}) : $signed({2'b0, r_pmag});
    assign w_dterm = r_dsign ? -$signed({2'b0, r_acc[21:8]}) : $signed({2'b0, r_acc[21:8]});
    assign w_diff  = w_pterm + w_dterm;
    assign w_left  = $signed({9'b0, r_base}) + $signed({w_diff[15], w_diff});
    assign w_right = $signed({9'b0, r_base}) - $signed({w_diff[15], w_diff});

    // ---------------------------------------------------------------- control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise   <= lfpd_pkg::RST_NOISE;
            r_line    <= lfpd_pkg::RST_LINE;
            r_pgain   <= lfpd_pkg::RST_PGAIN;
            r_dgain   <= lfpd_pkg::RST_DGAIN;
            r_base    <= lfpd_pkg::RST_BASE;
            r_max     <= lfpd_pkg::RST_MAX;
            r_lastpos <= '0;
            r_lasterr <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (w_wr) begin
                case (w_idx)
                    lfpd_pkg::REG_NOISE: r_noise <= pwdata[lfpd_pkg::SMP_W-1:0];
                    lfpd_pkg::REG_LINE:  r_line  <= pwdata[lfpd_pkg::SMP_W-1:0];
                    lfpd_pkg::REG_PGAIN: r_pgain <= pwdata[lfpd_pkg::SMP_W-1:0];
                    lfpd_pkg::REG_DGAIN: r_dgain <= pwdata[lfpd_pkg::SMP_W-1:0];
                    lfpd_pkg::REG_BASE:  r_base  <= pwdata[lfpd_pkg::SPD_W-1:0];
                    lfpd_pkg::REG_MAX:   r_max   <= pwdata[lfpd_pkg::SPD_W-1:0];
                    default:             r_max   <= r_max;
                endcase
            end
            // update history once the position of this item is final
            if (w_ctrl.err) begin
                r_lasterr <= w_err;
                if (r_divused) r_lastpos <= r_pos;
            end
            if (w_ctrl.done && w_out_free) r_ovalid <= 1'b1;
            else if (i_ready)              r_ovalid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- payload
    always_ff @(posedge i_clk) begin
        if (w_acc) r_smp <= i_data;

        if (w_ctrl.prep) begin
            r_pos     <= w_alt_pos;
            r_sum     <= w_sum;
            r_rem     <= {1'b0, w_wsum[22:12]};
            r_dvd     <= w_wsum[11:0];
            r_lost    <= w_lost;
            r_divused <= w_div;
        end

        // shift one quotient bit into the position per step
        if (w_ctrl.div) begin
            r_pos <= {r_pos[10:0], w_alu_carry};
            r_rem <= w_alu_carry ? w_alu_res[11:0] : w_alu_a[11:0];
            r_dvd <= {r_dvd[10:0], 1'b0};
        end

        if (w_ctrl.err) begin
            r_acc    <= '0;
            r_mcand  <= {10'b0, w_emag};
            r_mplier <= r_pgain;
            r_esign  <= w_err[12];
            r_dsign  <= w_derr[13];
            r_dmag   <= w_dmag;
        end

        // hand over from proportional to derivative product
        if (w_ctrl.mulp && w_ctrl.last) begin
            r_pmag   <= w_alu_res[21:8];
            r_acc    <= '0;
            r_mcand  <= {10'b0, r_dmag};
            r_mplier <= r_dgain;
        end else if (w_ctrl.mulp || w_ctrl.muld) begin
            r_acc    <= w_alu_res;
            r_mcand  <= {r_mcand[20:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[9:1]};
        end

        if (w_ctrl.done && w_out_free) begin
            if (r_lost) begin
                r_out <= '0;
            end else begin
                r_out.track_found   <= 1'b1;
                r_out.line_position <= r_pos;
                r_out.left_speed    <= clamp_speed(w_left, r_max);
                r_out.right_speed   <= clamp_speed(w_right, r_max);
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// ===== design/lfpd_alu.sv =====
`default_nettype none

// Shared adder/subtractor; carry out on subtract means a >= b
module lfpd_alu (
    input  wire logic [lfpd_pkg::ALU_W-1:0] i_a,
    input  wire logic [lfpd_pkg::ALU_W-1:0] i_b,
    input  wire logic                       i_sub,
    output logic      [lfpd_pkg::ALU_W-1:0] o_res,
    output logic                            o_carry
);

    logic [lfpd_pkg::ALU_W:0]   w_sum;
    logic [lfpd_pkg::ALU_W-1:0] w_b;

    assign w_b   = i_sub ? ~i_b : i_b;
    assign w_sum = {1'b0, i_a} + {1'b0, w_b} + {{lfpd_pkg::ALU_W{1'b0}}, i_sub};

    assign o_res   = w_sum[lfpd_pkg::ALU_W-1:0];
    assign o_carry = w_sum[lfpd_pkg::ALU_W];

endmodule

`default_nettype wire

// ===== design/lfpd_ctrl.sv =====
`default_nettype none

// Sequencer: steps the shared adder through divide and multiply loops
module lfpd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_lost,
    input  wire logic          i_div,
    input  wire logic          i_out_free,
    output lfpd_pkg::t_ctrl    o_ctrl
);

    lfpd_pkg::t_state                r_state, n_state;
    logic [lfpd_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic                            w_loop;
    logic                            w_last;

    assign w_loop = (r_state == lfpd_pkg::ST_DIV) || (r_state == lfpd_pkg::ST_MULP) ||
                    (r_state == lfpd_pkg::ST_MULD);
    assign w_last = (r_state == lfpd_pkg::ST_DIV) ? (r_cnt == lfpd_pkg::DIV_LAST)
                                                  : (r_cnt == lfpd_pkg::MUL_LAST);

    always_comb begin
        n_state = r_state;
        case (r_state)
            lfpd_pkg::ST_IDLE: begin
                if (i_start) n_state = lfpd_pkg::ST_PREP;
            end
            lfpd_pkg::ST_PREP: begin
                if (i_lost)     n_state = lfpd_pkg::ST_DONE;
                else if (i_div) n_state = lfpd_pkg::ST_DIV;
                else            n_state = lfpd_pkg::ST_ERR;
            end
            lfpd_pkg::ST_DIV: begin
                if (w_last) n_state = lfpd_pkg::ST_ERR;
            end
            lfpd_pkg::ST_ERR: begin
                n_state = lfpd_pkg::ST_MULP;
            end
            lfpd_pkg::ST_MULP: begin
                if (w_last) n_state = lfpd_pkg::ST_MULD;
            end
            lfpd_pkg::ST_MULD: begin
                if (w_last) n_state = lfpd_pkg::ST_DONE;
            end
            lfpd_pkg::ST_DONE: begin
                if (i_out_free) n_state = lfpd_pkg::ST_IDLE;
            end
            default: begin
                n_state = lfpd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_loop && !w_last) n_cnt = r_cnt + 1'b1;
        else                   n_cnt = '0;
    end

    always_comb begin
        o_ctrl      = '0;
        o_ctrl.last = w_loop && w_last;
        case (r_state)
            lfpd_pkg::ST_IDLE: o_ctrl.idle = 1'b1;
            lfpd_pkg::ST_PREP: o_ctrl.prep = 1'b1;
            lfpd_pkg::ST_DIV:  o_ctrl.div  = 1'b1;
            lfpd_pkg::ST_ERR:  o_ctrl.err  = 1'b1;
            lfpd_pkg::ST_MULP: o_ctrl.mulp = 1'b1;
            lfpd_pkg::ST_MULD: o_ctrl.muld = 1'b1;
            lfpd_pkg::ST_DONE: o_ctrl.done = 1'b1;
            default:           o_ctrl.idle = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfpd_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== design/lfpd_checker.sv =====
`default_nettype none

module lfpd_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire logic                           o_ready,
    input  wire logic                           o_valid,
    input  wire logic                           i_ready,
    input  wire lfpd_pkg::t_out                 o_data,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pready
);

    // one item at a time: drop ready after a transfer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken while an item is in work");

    // lost track stops both motors and reports no position
    a_lost_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.track_found) |->
        (o_data.left_speed == '0 && o_data.right_speed == '0 && o_data.line_position == '0))
        else $error("lost-track result not zeroed");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.line_position <= lfpd_pkg::POS_RIGHT))
        else $error("position beyond right edge");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable) |-> pready)
        else $error("register access stalled");

endmodule

bind line_follow_pd_steering_core lfpd_checker u_lfpd_checker (.*);

`default_nettype wire

// ===== bench/line_follow_pd_steering_core_tb.sv =====
`default_nettype none

module line_follow_pd_steering_core_tb;

    // Register slot beyond the last defined one; writes to it must change nothing
    localparam logic [2:0] REG_SPARE = 3'd6;

    localparam int WEIGHT_STEP = 1000;  // sensor weights 1000, 2000, 3000
    localparam int GAIN_SCALE  = 256;
    localparam int SMP_TOP     = 1023;
    localparam int THR_TOP     = 1000;
    localparam int N_PHASES    = 11;
    localparam int PHASE_ITEMS = 50;
    localparam lfpd_pkg::t_out TRACK_LOST = '0;

    typedef enum logic { ROW_FRAME, ROW_WRITE } t_row_kind;

    typedef struct {
        t_row_kind                   kind;
        logic [2:0]                  idx;
        logic [lfpd_pkg::DATA_W-1:0] value;
        lfpd_pkg::t_in               frame;
        bit                          typed;
        lfpd_pkg::t_out              want;
    } t_bench_row;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                        i_clk   = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    lfpd_pkg::t_in               i_data  = '0;
    logic                        i_ready = 1'b0;
    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [lfpd_pkg::ADDR_W-1:0] paddr   = '0;
    logic [lfpd_pkg::DATA_W-1:0] pwdata  = '0;

    logic                        o_ready;
    logic                        o_valid;
    lfpd_pkg::t_out              o_data;
    logic [lfpd_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    always #2 i_clk = ~i_clk;

    line_follow_pd_steering_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Steering predictor: its own copy of the registers and the history
    // ------------------------------------------------------------------
    logic [lfpd_pkg::SMP_W-1:0] pred_noise    = lfpd_pkg::RST_NOISE;
    logic [lfpd_pkg::SMP_W-1:0] pred_line     = lfpd_pkg::RST_LINE;
    logic [lfpd_pkg::SMP_W-1:0] pred_pgain    = lfpd_pkg::RST_PGAIN;
    logic [lfpd_pkg::SMP_W-1:0] pred_dgain    = lfpd_pkg::RST_DGAIN;
    logic [lfpd_pkg::SPD_W-1:0] pred_base     = lfpd_pkg::RST_BASE;
    logic [lfpd_pkg::SPD_W-1:0] pred_max      = lfpd_pkg::RST_MAX;
    logic [lfpd_pkg::POS_W-1:0] pred_last_pos = '0;
    int                         pred_last_err = 0;

    lfpd_pkg::t_out pending_steer [$];   // steering results still owed by the block
    t_bench_row     script [$];          // directed stimulus, walked in order
    int unsigned    flaws     = 0;
    int unsigned    gap_pct   = 30;
    int unsigned    stall_pct = 30;
    bit             calm      = 1'b0;
    lfpd_pkg::t_out want_now;

    function automatic logic [lfpd_pkg::SPD_W-1:0] clamp_drive(input int v);
        if (v < 0) return '0;
        if (v > int'(pred_max)) return pred_max;
        return v[lfpd_pkg::SPD_W-1:0];
    endfunction

    function automatic lfpd_pkg::t_out steer_predict(input lfpd_pkg::t_in f);
        int             smp [3];
        int             wsum, total, pos, err, diff;
        bit             seen;
        lfpd_pkg::t_out res;
        smp[0] = int'(f.sample_left_mid);
        smp[1] = int'(f.sample_centre);
        smp[2] = int'(f.sample_right_mid);
        wsum   = 0;
        total  = 0;
        seen   = 1'b0;
        res    = TRACK_LOST;
        for (int k = 0; k < 3; k++) begin
            if (smp[k] > int'(pred_line)) seen = 1'b1;
            if (smp[k] > int'(pred_noise)) begin
                wsum  += smp[k] * WEIGHT_STEP * (k + 1);
                total += smp[k];
            end
        end
        // Nothing above noise and no line: stop both motors, keep the history
        if (!seen && total == 0) return res;
        if (!seen) begin
            // Line lost: swing hard towards the side it was last seen on
            pos = (pred_last_pos < lfpd_pkg::POS_CENTRE) ? 0 : int'(lfpd_pkg::POS_RIGHT);
        end else if (total == 0) begin
            // Line seen yet filtered out as noise: hold the stored position
            pos = int'(pred_last_pos);
        end else begin
            pos = (wsum / total) & 12'hFFF;
            pred_last_pos = pos[lfpd_pkg::POS_W-1:0];
        end
        err  = pos - int'(lfpd_pkg::POS_CENTRE);
        diff = (err * int'(pred_pgain)) / GAIN_SCALE
             + ((err - pred_last_err) * int'(pred_dgain)) / GAIN_SCALE;
        pred_last_err = err;
        res.track_found   = 1'b1;
        res.line_position = pos[lfpd_pkg::POS_W-1:0];
        res.left_speed    = clamp_drive(int'(pred_base) + diff);
        res.right_speed   = clamp_drive(int'(pred_base) - diff);
        return res;
    endfunction

    function automatic int unsigned pick_level(input int unsigned hi);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return hi;
            default: return $urandom_range(0, hi);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Directed script builders
    // ------------------------------------------------------------------
    function automatic void add_frame(input int unsigned l, input int unsigned c,
                                      input int unsigned r, input bit typed = 1'b0,
                                      input lfpd_pkg::t_out want = '0);
        t_bench_row row;
        row.kind  = ROW_FRAME;
        row.idx   = '0;
        row.value = '0;
        row.frame.sample_left_mid  = l[lfpd_pkg::SMP_W-1:0];
        row.frame.sample_centre    = c[lfpd_pkg::SMP_W-1:0];
        row.frame.sample_right_mid = r[lfpd_pkg::SMP_W-1:0];
        row.typed = typed;
        row.want  = want;
        script.push_back(row);
    endfunction

    function automatic void add_write(input logic [2:0] idx,
                                      input logic [lfpd_pkg::DATA_W-1:0] val);
        t_bench_row row;
        row.kind  = ROW_WRITE;
        row.idx   = idx;
        row.value = val;
        row.frame = '0;
        row.typed = 1'b0;
        row.want  = '0;
        script.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Register write: setup phase, then access phase until pready; psel and penable then drop
    task automatic apb_write(input logic [2:0] idx, input logic [lfpd_pkg::DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        // Mirror the write in the predictor; unknown slots are dropped
        case (idx)
            lfpd_pkg::REG_NOISE: pred_noise = val[lfpd_pkg::SMP_W-1:0];
            lfpd_pkg::REG_LINE:  pred_line  = val[lfpd_pkg::SMP_W-1:0];
            lfpd_pkg::REG_PGAIN: pred_pgain = val[lfpd_pkg::SMP_W-1:0];
            lfpd_pkg::REG_DGAIN: pred_dgain = val[lfpd_pkg::SMP_W-1:0];
            lfpd_pkg::REG_BASE:  pred_base  = val[lfpd_pkg::SPD_W-1:0];
            lfpd_pkg::REG_MAX:   pred_max   = val[lfpd_pkg::SPD_W-1:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one frame, hold it until the transfer, then record what must come back
    task automatic send_frame(input lfpd_pkg::t_in f, input bit typed,
                              input lfpd_pkg::t_out want);
        lfpd_pkg::t_out model_out;
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= f;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        // Always run the predictor so its history follows typed rows as well
        model_out = steer_predict(f);
        pending_steer.push_back(typed ? want : model_out);
    endtask

    // Drop valid and wait until every owed result has been taken
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_steer.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall bursts, none once the run turns calm
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 99) < stall_pct) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    // Compare every result transfer with the oldest owed result, field by field
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_steer.size() == 0) begin
                flaws++;
                if (flaws <= 10)
                    $display("unexpected result: found=%0d pos=%0d l=%0d r=%0d",
                             o_data.track_found, o_data.line_position,
                             o_data.left_speed, o_data.right_speed);
            end else begin
                want_now = pending_steer.pop_front();
                if (o_data.track_found   !== want_now.track_found   ||
                    o_data.line_position !== want_now.line_position ||
                    o_data.left_speed    !== want_now.left_speed    ||
                    o_data.right_speed   !== want_now.right_speed) begin
                    flaws++;
                    if (flaws <= 10)
                        $display("mismatch: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want_now.track_found, want_now.line_position,
                                 want_now.left_speed, want_now.right_speed,
                                 o_data.track_found, o_data.line_position,
                                 o_data.left_speed, o_data.right_speed);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned smp [3];
        int unsigned mode, lane, v_noise, v_line, v_pgain, v_dgain, v_base, v_max;
        logic [lfpd_pkg::DATA_W-1:0] stain;
        lfpd_pkg::t_in frame;

        // Directed part, defaults after reset first
        add_frame(0, 0, 0, 1'b1, TRACK_LOST);                     // all dark
        add_frame(50, 50, 50, 1'b1, TRACK_LOST);                  // exactly at noise level
        add_frame(0, 1000, 0, 1'b1, '{1'b1, lfpd_pkg::POS_CENTRE,
                                      lfpd_pkg::RST_BASE, lfpd_pkg::RST_BASE});
        add_frame(SMP_TOP, SMP_TOP, SMP_TOP, 1'b1,
                  '{1'b1, lfpd_pkg::POS_CENTRE, lfpd_pkg::RST_BASE, lfpd_pkg::RST_BASE});
        add_frame(100, 0, 0);                 // line lost, stored position exactly centre
        add_frame(SMP_TOP, 0, 0);
        add_frame(0, 0, SMP_TOP);
        add_frame(120, 0, 60);                // line lost to the right
        add_frame(1000, 0, 0);
        add_frame(0, 51, 0);                  // line lost to the left
        add_frame(201, 200, 0);               // just over the line threshold
        add_frame(10'h155, 10'h2AA, 10'h3FF);
        add_frame(10'h2AA, 10'h155, 10'h000);
        add_frame(0, 0, 1, 1'b1, TRACK_LOST);
        // Line threshold under noise threshold: a line can be seen with nothing averaged
        add_write(lfpd_pkg::REG_NOISE, 300);
        add_write(lfpd_pkg::REG_LINE, 100);
        add_frame(150, 0, 0);
        add_frame(0, 150, 400);
        // Base above the clamp, full proportional gain, no derivative
        add_write(lfpd_pkg::REG_BASE, 255);
        add_write(lfpd_pkg::REG_MAX, 10);
        add_write(lfpd_pkg::REG_PGAIN, SMP_TOP);
        add_write(lfpd_pkg::REG_DGAIN, 0);
        add_write(REG_SPARE, 32'hFFFF_FFFF);
        add_frame(0, 0, 900);
        add_frame(900, 0, 0);
        // Both thresholds at zero: any light at all counts as line
        add_write(lfpd_pkg::REG_NOISE, 0);
        add_write(lfpd_pkg::REG_LINE, 0);
        add_frame(1, 0, 0);
        add_frame(0, 0, 0, 1'b1, TRACK_LOST);

        // Hold reset at the start, once
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[n]) begin
            if (script[n].kind == ROW_WRITE) begin
                settle();
                apb_write(script[n].idx, script[n].value);
            end else begin
                send_frame(script[n].frame, script[n].typed, script[n].want);
            end
        end

        // Random part: one register setting per phase, writes only while idle
        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            calm = (ph == N_PHASES - 1);
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 20;
                default: gap_pct = 50;
            endcase
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 20;
                default: stall_pct = 50;
            endcase
            case (ph)
                0: begin
                    v_noise = int'(lfpd_pkg::RST_NOISE);  v_line = int'(lfpd_pkg::RST_LINE);
                    v_pgain = int'(lfpd_pkg::RST_PGAIN);  v_dgain = int'(lfpd_pkg::RST_DGAIN);
                    v_base  = int'(lfpd_pkg::RST_BASE);   v_max  = int'(lfpd_pkg::RST_MAX);
                end
                1: begin
                    v_noise = THR_TOP;    v_line = THR_TOP;
                    v_pgain = SMP_TOP;    v_dgain = SMP_TOP;
                    v_base  = 255;        v_max  = 255;
                end
                2: begin
                    v_noise = 0;  v_line = 0;  v_pgain = 0;
                    v_dgain = 0;  v_base = 0;  v_max   = 0;
                end
                default: begin
                    v_noise = pick_level(THR_TOP);
                    v_line  = pick_level(THR_TOP);
                    v_pgain = pick_level(SMP_TOP);
                    v_dgain = pick_level(SMP_TOP);
                    v_base  = pick_level(255);
                    v_max   = pick_level(255);
                end
            endcase
            // Upper data bits carry junk now and then; only the register width counts
            stain = ($urandom_range(0, 3) == 0) ? ($urandom() << lfpd_pkg::SMP_W) : '0;
            apb_write(lfpd_pkg::REG_NOISE, stain | v_noise);
            apb_write(lfpd_pkg::REG_LINE,  stain | v_line);
            apb_write(lfpd_pkg::REG_PGAIN, stain | v_pgain);
            apb_write(lfpd_pkg::REG_DGAIN, stain | v_dgain);
            apb_write(lfpd_pkg::REG_BASE,  stain | v_base);
            apb_write(lfpd_pkg::REG_MAX,   stain | v_max);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                mode = $urandom_range(0, 19);
                if (mode < 10 && pred_line < SMP_TOP) begin
                    // Well-formed frame: line under one sensor, a neighbour perhaps lit
                    foreach (smp[k]) smp[k] = $urandom_range(0, int'(pred_noise));
                    lane = $urandom_range(0, 2);
                    smp[lane] = $urandom_range(int'(pred_line) + 1, SMP_TOP);
                    if ($urandom_range(0, 1))
                        smp[(lane == 1) ? $urandom_range(0, 1) * 2 : 1] =
                            $urandom_range(0, SMP_TOP);
                end else if (mode < 13 && pred_noise < pred_line) begin
                    // Some light, none of it the line
                    foreach (smp[k])
                        smp[k] = $urandom_range(0, 1)
                               ? $urandom_range(int'(pred_noise) + 1, int'(pred_line))
                               : $urandom_range(0, int'(pred_noise));
                end else if (mode < 15) begin
                    foreach (smp[k]) smp[k] = $urandom_range(0, int'(pred_noise));
                end else begin
                    foreach (smp[k]) smp[k] = $urandom_range(0, SMP_TOP);
                end
                frame.sample_left_mid  = smp[0][lfpd_pkg::SMP_W-1:0];
                frame.sample_centre    = smp[1][lfpd_pkg::SMP_W-1:0];
                frame.sample_right_mid = smp[2][lfpd_pkg::SMP_W-1:0];
                send_frame(frame, 1'b0, TRACK_LOST);
            end
        end

        // Drain, then allow the longest latency for any stray result
        settle();
        repeat (48) @(posedge i_clk);
        if (flaws == 0 && pending_steer.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
